### design/lcg48_pkg.sv
// shared constants, operation codes and sequencer states for the 48-bit lcg generator
// no dependencies; imported by lcg48_random_generator, lcg48_checker and the testbench
package lcg48_pkg;

    localparam int STATE_W = 48;
    localparam int MULT_W  = 35;
    localparam int LANE_W  = 16;
    localparam int OP_W    = 3;
    localparam int BOUND_W = 31;
    localparam int VALUE_W = 64;
    localparam int STEP_W  = 5;

    localparam logic [MULT_W-1:0]  LCG_MULT = 35'h5DEECE66D;
    localparam logic [STATE_W-1:0] LCG_INCR = 48'hB;

    localparam logic [OP_W-1:0] OP_INT     = 3'd0;
    localparam logic [OP_W-1:0] OP_BOUNDED = 3'd1;
    localparam logic [OP_W-1:0] OP_LONG    = 3'd2;
    localparam logic [OP_W-1:0] OP_BOOL    = 3'd3;
    localparam logic [OP_W-1:0] OP_FLOAT   = 3'd4;
    localparam logic [OP_W-1:0] OP_DOUBLE  = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_EVAL,
        ST_DIV,
        ST_CHECK,
        ST_DONE
    } seq_state_t;

endpackage

### design/lcg48_random_generator.sv
// top level of the 48-bit linear congruential random generator
// depends on lcg48_pkg for constants, operation codes and sequencer states
//
// Each request word selects one operation (int, bounded int, long, boolean, float fraction
// or double fraction) and yields exactly one result word. The 48-bit state advances as
// state * 0x5DEECE66D + 0xB mod 2^48; the multiply is done by one 16 x 35 bit partial
// product unit, one 16-bit lane of the state at a time. Int, boolean and float requests
// take one draw, long and double take two. A bounded request with a power-of-two bound
// is scaled from one draw; any other bound runs a restoring divider one quotient bit per
// cycle after each draw, and every rejected draw is followed by a redraw, divide and
// check. Only one request is in flight: stall is held from acceptance until the result
// word has been taken, and also while a seed write is on offer. Unused op codes return 0
// in the cycle after acceptance and leave the state alone. Writing the seed reloads the
// state with (seed xor 0x5DEECE66D) on the low 48 bits; cfg_ready is high only
// while idle.
module lcg48_random_generator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [lcg48_pkg::OP_W-1:0]    op,
    input  logic [lcg48_pkg::BOUND_W-1:0] bound,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [lcg48_pkg::VALUE_W-1:0] value,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [63:0]                   seed
);
    import lcg48_pkg::*;

    // sequencer and datapath registers
    seq_state_t           st_reg, st_next;
    logic [STATE_W-1:0]   lcg_reg, lcg_next;
    logic [STATE_W-1:0]   acc_reg, acc_next;
    logic [1:0]           cnt_reg, cnt_next;
    logic [OP_W-1:0]      op_reg, op_next;
    logic [BOUND_W-1:0]   bound_reg, bound_next;
    logic                 second_reg, second_next;
    logic [31:0]          first_reg, first_next;
    logic [BOUND_W-1:0]   rem_reg, rem_next;
    logic [BOUND_W-1:0]   dvd_reg, dvd_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [VALUE_W-1:0]   value_reg, value_next;

    // helper signals
    logic                 in_take;
    logic                 cfg_take;
    logic [LANE_W-1:0]    lane;
    logic [LANE_W+MULT_W-1:0] prod;
    logic [STATE_W-1:0]   part;
    logic [STATE_W-1:0]   acc_sum;
    logic [31:0]          d32;
    logic [BOUND_W-1:0]   d31;
    logic                 pow2;
    logic [2*BOUND_W-1:0] scaled;
    logic [BOUND_W:0]     shifted;
    logic [BOUND_W:0]     trial;
    logic [31:0]          accept_chk;

    assign in_stall  = (st_reg != ST_IDLE) | cfg_valid;
    assign cfg_ready = (st_reg == ST_IDLE);
    assign in_take   = in_valid & ~in_stall;
    assign cfg_take  = cfg_valid & cfg_ready;
    assign out_valid = (st_reg == ST_DONE);
    assign value     = value_reg;

    // draws taken from the freshly advanced state
    assign d32 = lcg_reg[STATE_W-1 -: 32];
    assign d31 = lcg_reg[STATE_W-1 -: BOUND_W];

    // one 16-bit lane of the state times the multiplier, placed at its lane offset
    always_comb
    begin
        case (cnt_reg)
            2'd0:    lane = lcg_reg[LANE_W-1:0];
            2'd1:    lane = lcg_reg[2*LANE_W-1:LANE_W];
            2'd2:    lane = lcg_reg[3*LANE_W-1:2*LANE_W];
            default: lane = '0;
        endcase
    end

    assign prod = {{MULT_W{1'b0}}, lane} * {{LANE_W{1'b0}}, LCG_MULT};

    always_comb
    begin
        case (cnt_reg)
            2'd0:    part = prod[STATE_W-1:0];
            2'd1:    part = {prod[STATE_W-LANE_W-1:0], {LANE_W{1'b0}}};
            2'd2:    part = {prod[STATE_W-2*LANE_W-1:0], {(2*LANE_W){1'b0}}};
            default: part = '0;
        endcase
    end

    assign acc_sum = acc_reg + part;

    // bounded int: power-of-two test, fast-path scaling, divider step and rejection test
    assign pow2    = ((bound_reg & (~bound_reg + BOUND_W'(1))) == bound_reg);
    assign scaled  = {{BOUND_W{1'b0}}, bound_reg} * {{BOUND_W{1'b0}}, d31};
    assign shifted = {rem_reg, dvd_reg[BOUND_W-1]};
    assign trial   = shifted - {1'b0, bound_reg};
    assign accept_chk = {1'b0, d31} - {1'b0, rem_reg} + {1'b0, bound_reg} - 32'd1;

    // next state
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    if (op <= OP_DOUBLE)
                        st_next = ST_MUL;
                    else
                        st_next = ST_DONE;
                end
            end
            ST_MUL:
            begin
                if (cnt_reg == 2'd2)
                    st_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                case (op_reg)
                    OP_LONG, OP_DOUBLE:
                        st_next = second_reg ? ST_DONE : ST_MUL;
                    OP_BOUNDED:
                        st_next = pow2 ? ST_DONE : ST_DIV;
                    default:
                        st_next = ST_DONE;
                endcase
            end
            ST_DIV:
            begin
                if (step_reg == STEP_W'(BOUND_W - 1))
                    st_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                st_next = accept_chk[31] ? ST_MUL : ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_stall)
                    st_next = ST_IDLE;
            end
            default:
                st_next = ST_IDLE;
        endcase
    end

    // datapath updates
    always_comb
    begin
        lcg_next    = lcg_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        op_next     = op_reg;
        bound_next  = bound_reg;
        second_next = second_reg;
        first_next  = first_reg;
        rem_next    = rem_reg;
        dvd_next    = dvd_reg;
        step_next   = step_reg;
        value_next  = value_reg;
        case (st_reg)
            ST_IDLE:
            begin
                if (cfg_take)
                    lcg_next = seed[STATE_W-1:0] ^ {{(STATE_W-MULT_W){1'b0}}, LCG_MULT};
                if (in_take)
                begin
                    op_next     = op;
                    bound_next  = bound;
                    second_next = 1'b0;
                    acc_next    = LCG_INCR;
                    cnt_next    = 2'd0;
                    value_next  = '0;
                end
            end
            ST_MUL:
            begin
                acc_next = acc_sum;
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd2)
                    lcg_next = acc_sum;
            end
            ST_EVAL:
            begin
                case (op_reg)
                    OP_INT:
                        value_next = {{32{d32[31]}}, d32};
                    OP_LONG:
                    begin
                        if (!second_reg)
                        begin
                            first_next  = d32;
                            second_next = 1'b1;
                            acc_next    = LCG_INCR;
                            cnt_next    = 2'd0;
                        end
                        else
                            // sign-extended low word folds into the high word as a borrow
                            value_next = {first_reg - {31'd0, d32[31]}, d32};
                    end
                    OP_BOOL:
                        value_next = {{(VALUE_W-1){1'b0}}, lcg_reg[STATE_W-1]};
                    OP_FLOAT:
                        value_next = {{(VALUE_W-24){1'b0}}, lcg_reg[STATE_W-1 -: 24]};
                    OP_DOUBLE:
                    begin
                        if (!second_reg)
                        begin
                            first_next  = {6'd0, lcg_reg[STATE_W-1 -: 26]};
                            second_next = 1'b1;
                            acc_next    = LCG_INCR;
                            cnt_next    = 2'd0;
                        end
                        else
                            value_next = {11'd0, first_reg[25:0], lcg_reg[STATE_W-1 -: 27]};
                    end
                    OP_BOUNDED:
                    begin
                        if (pow2)
                            value_next = {{(VALUE_W-BOUND_W){1'b0}},
                                          scaled[2*BOUND_W-1:BOUND_W]};
                        else
                        begin
                            rem_next  = '0;
                            dvd_next  = d31;
                            step_next = '0;
                        end
                    end
                    default:
                        value_next = '0;
                endcase
            end
            ST_DIV:
            begin
                // restoring step, one remainder bit per cycle
                if (!trial[BOUND_W])
                    rem_next = trial[BOUND_W-1:0];
                else
                    rem_next = shifted[BOUND_W-1:0];
                dvd_next  = {dvd_reg[BOUND_W-2:0], 1'b0};
                step_next = step_reg + STEP_W'(1);
            end
            ST_CHECK:
            begin
                if (accept_chk[31])
                begin
                    acc_next = LCG_INCR;
                    cnt_next = 2'd0;
                end
                else
                    value_next = {{(VALUE_W-BOUND_W){1'b0}}, rem_reg};
            end
            default:
            begin
            end
        endcase
    end

    // control state and generator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= ST_IDLE;
            lcg_reg <= {{(STATE_W-MULT_W){1'b0}}, LCG_MULT};
        end
        else
        begin
            st_reg  <= st_next;
            lcg_reg <= lcg_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        cnt_reg    <= cnt_next;
        op_reg     <= op_next;
        bound_reg  <= bound_next;
        second_reg <= second_next;
        first_reg  <= first_next;
        rem_reg    <= rem_next;
        dvd_reg    <= dvd_next;
        step_reg   <= step_next;
        value_reg  <= value_next;
    end

endmodule

### design/lcg48_checker.sv
// port-level checker for lcg48_random_generator, with its bind statement
// depends on lcg48_pkg for operation codes
module lcg48_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic [lcg48_pkg::OP_W-1:0]    op,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [lcg48_pkg::VALUE_W-1:0] value,
    input logic                          cfg_ready
);
    import lcg48_pkg::*;

    // a held result word stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(value))
        else $error("result word changed while stalled");

    // no new request while a result is waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("request taken while result pending");

    // seed writes are refused while a request is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !cfg_ready)
        else $error("seed port open during a request");

    // boolean takes one draw and returns 0 or 1
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && op == OP_BOOL |-> ##5 (out_valid && value[63:1] == '0))
        else $error("boolean result late or out of range");

endmodule

bind lcg48_random_generator lcg48_checker u_lcg48_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .cfg_ready (cfg_ready)
);

### tb/sv/lcg48_random_generator_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the 48-bit lcg random generator: directed then random requests
// depends on lcg48_pkg and lcg48_random_generator; the expected values come from its own lcg copy
module lcg48_random_generator_tb;
    import lcg48_pkg::*;

    // unused op codes, answered with zero and no state change
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    localparam logic [47:0] MULT_48 = 48'h0005_DEEC_E66D;
    localparam logic [47:0] INCR_48 = 48'h0000_0000_000B;

    localparam int RESET_CYCLES    = 12;
    localparam int REQS_PER_PHASE  = 275;
    localparam int NUM_PHASES      = 6;
    localparam int HOLD_CYCLES     = 400;
    localparam int TAIL_CYCLES     = 80;
    localparam int CYCLE_LIMIT     = 1000000;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [BOUND_W-1:0] bound;
    } request_t;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] value;
    } draw_result_t;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid  = 1'b0;
    logic                          in_stall;
    logic [OP_W-1:0]               op        = '0;
    logic [BOUND_W-1:0]            bound     = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic signed [VALUE_W-1:0]     value;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [63:0]                   seed      = '0;

    // stimulus and scoreboard storage
    request_t     request_q[$];
    draw_result_t draw_result_q[$];

    // shadow of the generator state
    logic [47:0]  lcg_shadow;

    int           queued_cnt    = 0;
    int           accepted_cnt  = 0;
    int           mismatch_cnt  = 0;
    int           cycle_cnt     = 0;

    // knobs steered by the sequencer, read by the driver and monitor
    int           tx_idle_pct   = 0;
    int           rx_idle_pct   = 0;
    logic         tx_pause      = 1'b0;
    int           hold_req      = 0;

    lcg48_random_generator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .bound     (bound),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .seed      (seed)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // step the shadow lcg once and hand back the top nbits as a 32-bit pattern
    function automatic logic [31:0] advance_lcg(input int nbits);
        logic [47:0] shifted;
        lcg_shadow = lcg_shadow * MULT_48 + INCR_48;
        shifted = lcg_shadow >> (48 - nbits);
        return shifted[31:0];
    endfunction

    // int below a bound: power-of-two scaling, else modulo with rejection
    // a zero bound falls into the power-of-two path and gives zero
    function automatic logic [63:0] pick_below(input logic [31:0] lim);
        logic [31:0] r;
        logic [31:0] rem;
        logic [31:0] t;
        logic [63:0] prod;
        logic        done;
        if ((lim & (~lim + 32'd1)) == lim)
        begin
            r = advance_lcg(31);
            prod = {32'd0, lim} * {32'd0, r};
            return prod >> 31;
        end
        done = 1'b0;
        rem  = '0;
        while (!done)
        begin
            r    = advance_lcg(31);
            rem  = r % lim;
            t    = r - rem + (lim - 32'd1);
            // redraw while the top of the bucket spills past the signed range
            done = !t[31];
        end
        return {32'd0, rem};
    endfunction

    function automatic logic [63:0] predict_draw(input logic [OP_W-1:0] code,
                                                 input logic [BOUND_W-1:0] lim);
        logic [31:0] hi;
        logic [31:0] lo;
        logic [63:0] v;
        case (code)
            OP_INT:
            begin
                hi = advance_lcg(32);
                v  = {{32{hi[31]}}, hi};
            end
            OP_BOUNDED:
                v = pick_below({1'b0, lim});
            OP_LONG:
            begin
                hi = advance_lcg(32);
                lo = advance_lcg(32);
                v  = ({{32{hi[31]}}, hi} << 32) + {{32{lo[31]}}, lo};
            end
            OP_BOOL:
            begin
                hi = advance_lcg(1);
                v  = (hi != 32'd0) ? 64'd1 : 64'd0;
            end
            OP_FLOAT:
                v = {32'd0, advance_lcg(24)};
            OP_DOUBLE:
            begin
                hi = advance_lcg(26);
                lo = advance_lcg(27);
                v  = ({32'd0, hi} << 27) + {32'd0, lo};
            end
            default:
                v = '0;
        endcase
        return v;
    endfunction

    // random request: mostly legal ops, a few spare codes, bounds spread over
    // powers of two, small values, rejection-heavy values and the full range
    function automatic request_t random_request();
        request_t r;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            r.op = ($urandom_range(0, 1) == 0) ? OP_SPARE_LO : OP_SPARE_HI;
        else
            r.op = OP_W'($urandom_range(0, 5));
        pick = $urandom_range(0, 99);
        if (pick < 1)
            r.bound = '0;
        else if (pick < 30)
            r.bound = BOUND_W'(32'd1 << $urandom_range(0, 30));
        else if (pick < 55)
            r.bound = BOUND_W'($urandom_range(1, 100));
        else if (pick < 65)
            r.bound = BOUND_W'(32'h4000_0000 + $urandom_range(1, 16'hFFFF));
        else if (pick < 75)
            r.bound = BOUND_W'(32'h7FFF_FFFF - $urandom_range(0, 255));
        else
            r.bound = BOUND_W'($urandom);
        return r;
    endfunction

    task automatic queue_request(input logic [OP_W-1:0] code, input logic [BOUND_W-1:0] lim);
        request_t r;
        r.op    = code;
        r.bound = lim;
        request_q.push_back(r);
        queued_cnt++;
    endtask

    // wait until every queued word went in and every result word came back
    task automatic wait_drained();
        while (accepted_cnt != queued_cnt || draw_result_q.size() != 0)
            @(posedge clk);
    endtask

    // seed write over the config channel, only ever issued with the block idle
    task automatic write_seed(input logic [63:0] s);
        @(posedge clk);
        cfg_valid <= 1'b1;
        seed      <= s;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // driver: takes the next request word off the queue once the previous
    // one has been accepted, and predicts the result at acceptance
    always @(posedge clk or negedge rst_n)
    begin
        request_t nxt;
        logic     fire;
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            op          <= '0;
            bound       <= '0;
            lcg_shadow  = MULT_48;
        end
        else
        begin
            fire = in_valid && !in_stall;
            if (fire)
            begin
                nxt.op    = op;
                nxt.bound = bound;
                draw_result_q.push_back({op, predict_draw(nxt.op, nxt.bound)});
                // count only after the push so the sequencer never sees a gap
                accepted_cnt++;
            end
            if (cfg_valid && cfg_ready)
            begin
                lcg_shadow  = seed[47:0] ^ MULT_48;
            end
            // a word on offer stays put until it is taken
            if (!in_valid || fire)
            begin
                if (request_q.size() != 0 && !tx_pause &&
                    $urandom_range(0, 99) >= tx_idle_pct)
                begin
                    nxt = request_q.pop_front();
                    in_valid <= 1'b1;
                    op       <= nxt.op;
                    bound    <= nxt.bound;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each result word against the oldest prediction and
    // drives the receiver stall, including the long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        draw_result_t want;
        int           hold_left;
        int           hold_seen;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left = 0;
            hold_seen = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (draw_result_q.size() == 0)
                begin
                    $display("%0t: result word with nothing pending, actual %h", $time, value);
                    mismatch_cnt++;
                end
                else
                begin
                    want = draw_result_q.pop_front();
                    if (value !== want.value)
                    begin
                        $display("%0t: op %0d value mismatch, expected %h actual %h",
                                 $time, want.op, want.value, value);
                        mismatch_cnt++;
                    end
                end
            end
            if (hold_seen != hold_req)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
            end
        end
    end

    // watchdog on a hung handshake
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // sequencer: reset, directed words on the reset state, then random phases
    // each behind its own seed write
    initial
    begin
        logic [63:0] phase_seed;
        int          ph;
        int          k;
        request_t    r;

        rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        tx_idle_pct <= 17;
        rx_idle_pct <= 70;

        // directed words on the scrambled zero seed
        queue_request(OP_INT,     '0);
        queue_request(OP_BOUNDED, 31'd1);
        queue_request(OP_BOUNDED, 31'd2);
        queue_request(OP_BOUNDED, 31'h4000_0000);         // largest power of two
        queue_request(OP_BOUNDED, '0);                    // zero bound
        queue_request(OP_BOUNDED, 31'h7FFF_FFFF);         // largest bound
        queue_request(OP_BOUNDED, 31'd3);
        queue_request(OP_BOUNDED, 31'h4000_0001);         // rejection on about half the draws
        queue_request(OP_BOUNDED, 31'h4000_0001);
        queue_request(OP_BOUNDED, 31'h5555_5555);
        queue_request(OP_LONG,    31'h7FFF_FFFF);
        queue_request(OP_BOOL,    '0);
        queue_request(OP_BOOL,    31'h7FFF_FFFF);
        queue_request(OP_FLOAT,   '0);
        queue_request(OP_DOUBLE,  '0);
        queue_request(OP_SPARE_LO, 31'h7FFF_FFFF);        // spare codes leave the state alone
        queue_request(OP_SPARE_HI, '0);
        queue_request(OP_INT,     31'h7FFF_FFFF);         // bound ignored outside bounded int
        queue_request(OP_LONG,    '0);
        queue_request(OP_DOUBLE,  31'h7FFF_FFFF);
        queue_request(OP_FLOAT,   31'h2AAA_AAAA);
        queue_request(OP_BOOL,    '0);
        wait_drained();

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            // idling: sender light/receiver heavy, then swapped, then none
            if (ph == 2)
            begin
                tx_idle_pct <= 70;
                rx_idle_pct <= 17;
            end
            else if (ph == 4)
            begin
                tx_idle_pct <= 0;
                rx_idle_pct <= 0;
            end
            case (ph)
                0:       phase_seed = 64'h0000_0005_DEEC_E66D;   // scrambles to a zero state
                1:       phase_seed = '1;
                2:       phase_seed = '0;
                3:       phase_seed = 64'h8000_0000_0000_0000;
                default: phase_seed = {$urandom, $urandom};
            endcase
            write_seed(phase_seed);

            for (k = 0; k < REQS_PER_PHASE; k++)
            begin
                r = random_request();
                queue_request(r.op, r.bound);
            end

            // long receiver hold-off while the sender keeps offering words
            if (ph == 4)
                hold_req <= hold_req + 1;

            // sender pause mid-phase until everything in flight has come back
            if (ph == 3)
            begin
                while (accepted_cnt < queued_cnt - REQS_PER_PHASE / 2)
                    @(posedge clk);
                tx_pause <= 1'b1;
                @(posedge clk);
                while (draw_result_q.size() != 0 || in_valid)
                    @(posedge clk);
                tx_pause <= 1'b0;
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0 && draw_result_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### sim.f
design/lcg48_pkg.sv
design/lcg48_random_generator.sv
design/lcg48_checker.sv
tb/sv/lcg48_random_generator_tb.sv
